@@ hw/rtl/ecal_pkg.sv @@
// Shared constants, types and the month table for the epoch to calendar converter.
`timescale 1ns / 1ps

package ecal_pkg;

  localparam int unsigned Stages = 7;

  localparam logic [33:0] LimitSecs  = 34'd4102444800;
  localparam logic [33:0] SecsHour   = 34'd3600;
  localparam logic [31:0] SecsDay    = 32'd86400;

  localparam logic [25:0] DayRecip   = 26'd50903317;
  localparam int unsigned DayShift   = 35;
  localparam logic [15:0] DaysTo1970 = 16'd731;
  localparam logic [16:0] CycRecip   = 17'd91868;
  localparam int unsigned CycShift   = 27;
  localparam logic [15:0] CycDays    = 16'd1461;
  localparam logic [17:0] HourRecip  = 18'd149131;
  localparam int unsigned HourShift  = 29;
  localparam logic [16:0] HourSecs   = 17'd3600;
  localparam logic [14:0] MinRecip   = 15'd17477;
  localparam int unsigned MinShift   = 20;
  localparam logic [11:0] MinSecs    = 12'd60;
  localparam logic [11:0] BaseYear   = 12'd1968;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        out_of_range;
  } ecal_result_t;

  // Zero-based day of year on which month m (0 to 11) begins.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/epoch_seconds_to_calendar_top.sv @@
// Top level of the epoch seconds to calendar converter: handshake, offset register, pipeline.
//
//   Channel  Direction  Handshake            Payload
//   in       request    in_valid / in_stall  in_epoch_seconds
//   out      result     out_valid/out_stall  out_year .. out_out_of_range
//   cfg      write      cfg_we               cfg_wdata (time-zone offset)
//
// Each request passes seven register stages, the last of which is the output register;
// one request can be accepted every cycle while the output is not stalled.
// The stages advance together whenever the output register is empty or taken.
// A stalled output holds every stage, and in_stall is raised for that cycle.
// Reset empties the pipeline and clears the offset to zero.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic        out_out_of_range,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  logic [ecal_pkg::Stages-1:0] vld_r, vld_nxt;
  logic [4:0]                  tz_r;
  logic                        en;
  ecal_pkg::ecal_result_t      res;

  assign out_valid = vld_r[ecal_pkg::Stages-1];
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign vld_nxt   = {vld_r[ecal_pkg::Stages-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      tz_r  <= 5'd0;
    end else begin
      if (en) begin
        vld_r <= vld_nxt;
      end
      if (cfg_we) begin
        tz_r <= cfg_wdata;
      end
    end
  end

  ecal_conv u_conv (
    .clk             (clk),
    .en              (en),
    .epoch_seconds   (in_epoch_seconds),
    .tz_offset_hours (tz_r),
    .res             (res)
  );

  assign out_year         = res.year;
  assign out_month        = res.month;
  assign out_day_of_month = res.day_of_month;
  assign out_hour         = res.hour;
  assign out_minute       = res.minute;
  assign out_second       = res.second;
  assign out_out_of_range = res.out_of_range;

endmodule

@@ hw/rtl/ecal_conv.sv @@
// Datapath pipeline that turns adjusted epoch seconds into calendar fields.
`timescale 1ns / 1ps

module ecal_conv (
  input  logic                  clk,
  input  logic                  en,
  input  logic [31:0]           epoch_seconds,
  input  logic [4:0]            tz_offset_hours,
  output ecal_pkg::ecal_result_t res
);

  // Stage 1: apply the offset and check the range.
  logic [31:0] s1_t_r,   s1_t_nxt;
  logic        s1_oor_r, s1_oor_nxt;
  logic [33:0] t_adj;

  always_comb begin
    t_adj = {2'b00, epoch_seconds}
          + 34'($signed({{29{tz_offset_hours[4]}}, tz_offset_hours}) * $signed(ecal_pkg::SecsHour));
    s1_oor_nxt = t_adj[33] || (t_adj >= ecal_pkg::LimitSecs);
    s1_t_nxt   = t_adj[31:0];
  end

  // Stage 2: whole days.
  logic [31:0] s2_t_r;
  logic        s2_oor_r;
  logic [15:0] s2_days_r, s2_days_nxt;
  logic [50:0] day_prod;

  always_comb begin
    day_prod    = 51'(s1_t_r[31:7]) * 51'(ecal_pkg::DayRecip);
    s2_days_nxt = 16'(day_prod >> ecal_pkg::DayShift);
  end

  // Stage 3: time of day and four-year cycle count.
  logic        s3_oor_r;
  logic [16:0] s3_tod_r, s3_tod_nxt;
  logic [15:0] s3_dp_r,  s3_dp_nxt;
  logic [5:0]  s3_cyc_r, s3_cyc_nxt;
  logic [31:0] tod_full;
  logic [32:0] cyc_prod;

  always_comb begin
    tod_full   = s2_t_r - (32'(s2_days_r) * ecal_pkg::SecsDay);
    s3_tod_nxt = tod_full[16:0];
    s3_dp_nxt  = s2_days_r + ecal_pkg::DaysTo1970;
    cyc_prod   = 33'(s3_dp_nxt) * 33'(ecal_pkg::CycRecip);
    s3_cyc_nxt = 6'(cyc_prod >> ecal_pkg::CycShift);
  end

  // Stage 4: day within the cycle and hour.
  logic        s4_oor_r;
  logic [16:0] s4_tod_r;
  logic [5:0]  s4_cyc_r;
  logic [10:0] s4_r_r,    s4_r_nxt;
  logic [4:0]  s4_hour_r, s4_hour_nxt;
  logic [15:0] r_full;
  logic [35:0] hour_prod;

  always_comb begin
    r_full      = s3_dp_r - (16'(s3_cyc_r) * ecal_pkg::CycDays);
    s4_r_nxt    = r_full[10:0];
    hour_prod   = 36'(s3_tod_r) * 36'(ecal_pkg::HourRecip);
    s4_hour_nxt = 5'(hour_prod >> ecal_pkg::HourShift);
  end

  // Stage 5: year, day of year and seconds within the hour.
  logic        s5_oor_r;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_year_r, s5_year_nxt;
  logic        s5_leap_r, s5_leap_nxt;
  logic [8:0]  s5_doy_r,  s5_doy_nxt;
  logic [11:0] s5_rem_r,  s5_rem_nxt;
  logic [1:0]  yoff;
  logic [10:0] ybase;
  logic [16:0] rem_full;

  always_comb begin
    if (s4_r_r < 11'd366) begin
      yoff  = 2'd0;
      ybase = 11'd0;
    end else if (s4_r_r < 11'd731) begin
      yoff  = 2'd1;
      ybase = 11'd366;
    end else if (s4_r_r < 11'd1096) begin
      yoff  = 2'd2;
      ybase = 11'd731;
    end else begin
      yoff  = 2'd3;
      ybase = 11'd1096;
    end
    s5_doy_nxt  = 9'(s4_r_r - ybase);
    s5_leap_nxt = (yoff == 2'd0);
    s5_year_nxt = ecal_pkg::BaseYear + {4'd0, s4_cyc_r, 2'b00} + {10'd0, yoff};
    rem_full    = s4_tod_r - (17'(s4_hour_r) * ecal_pkg::HourSecs);
    s5_rem_nxt  = rem_full[11:0];
  end

  // Stage 6: month, day of month and minute.
  logic        s6_oor_r;
  logic [4:0]  s6_hour_r;
  logic [11:0] s6_year_r;
  logic [11:0] s6_rem_r;
  logic [3:0]  s6_mon_r, s6_mon_nxt;
  logic [4:0]  s6_day_r, s6_day_nxt;
  logic [5:0]  s6_min_r, s6_min_nxt;
  logic [8:0]  mstart;
  logic [26:0] min_prod;

  always_comb begin
    s6_mon_nxt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s5_doy_r >= ecal_pkg::month_start(s5_leap_r, 4'(m))) begin
        s6_mon_nxt = 4'(m);
      end
    end
    mstart     = ecal_pkg::month_start(s5_leap_r, s6_mon_nxt);
    s6_day_nxt = 5'(s5_doy_r - mstart);
    min_prod   = 27'(s5_rem_r) * 27'(ecal_pkg::MinRecip);
    s6_min_nxt = 6'(min_prod >> ecal_pkg::MinShift);
  end

  // Stage 7: second and the output register.
  ecal_pkg::ecal_result_t res_r, res_nxt;
  logic [11:0] sec_full;

  always_comb begin
    sec_full = s6_rem_r - (12'(s6_min_r) * ecal_pkg::MinSecs);
    if (s6_oor_r) begin
      res_nxt              = '0;
      res_nxt.out_of_range = 1'b1;
    end else begin
      res_nxt.year         = s6_year_r;
      res_nxt.month        = s6_mon_r + 4'd1;
      res_nxt.day_of_month = s6_day_r + 5'd1;
      res_nxt.hour         = s6_hour_r;
      res_nxt.minute       = s6_min_r;
      res_nxt.second       = sec_full[5:0];
      res_nxt.out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r    <= s1_t_nxt;
      s1_oor_r  <= s1_oor_nxt;
      s2_t_r    <= s1_t_r;
      s2_oor_r  <= s1_oor_r;
      s2_days_r <= s2_days_nxt;
      s3_oor_r  <= s2_oor_r;
      s3_tod_r  <= s3_tod_nxt;
      s3_dp_r   <= s3_dp_nxt;
      s3_cyc_r  <= s3_cyc_nxt;
      s4_oor_r  <= s3_oor_r;
      s4_tod_r  <= s3_tod_r;
      s4_cyc_r  <= s3_cyc_r;
      s4_r_r    <= s4_r_nxt;
      s4_hour_r <= s4_hour_nxt;
      s5_oor_r  <= s4_oor_r;
      s5_hour_r <= s4_hour_r;
      s5_year_r <= s5_year_nxt;
      s5_leap_r <= s5_leap_nxt;
      s5_doy_r  <= s5_doy_nxt;
      s5_rem_r  <= s5_rem_nxt;
      s6_oor_r  <= s5_oor_r;
      s6_hour_r <= s5_hour_r;
      s6_year_r <= s5_year_r;
      s6_rem_r  <= s5_rem_r;
      s6_mon_r  <= s6_mon_nxt;
      s6_day_r  <= s6_day_nxt;
      s6_min_r  <= s6_min_nxt;
      res_r     <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ tb/sv/tb_epoch_seconds_to_calendar_top.sv @@
// Self-checking testbench for the epoch seconds to calendar converter, with random handshake gaps.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_top;

  typedef ecal_pkg::ecal_result_t ecal_result_t;

  localparam longint RangeEnd = 64'd4102444800;
  localparam int IdleLimit = 1000;
  localparam int PhaseCount = 10;
  localparam int PhaseItems = 110;

  localparam logic [4:0] TzZero    = 5'h00;
  localparam logic [4:0] TzMinus1  = 5'h1F;
  localparam logic [4:0] TzPlus14  = 5'h0E;
  localparam logic [4:0] TzMinus12 = 5'h14;
  localparam logic [4:0] TzMinus16 = 5'h10;
  localparam logic [4:0] TzPlus15  = 5'h0F;

  localparam ecal_result_t FirstSecond = {12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0};
  localparam ecal_result_t LastSecond  = {12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0};
  localparam ecal_result_t FirstAt15h  = {12'd1970, 4'd1, 5'd1, 5'd15, 6'd0, 6'd0, 1'b0};
  localparam ecal_result_t Beyond      = 39'd1;
  localparam ecal_result_t Predicted   = 39'd0;

  typedef struct packed {
    logic [4:0]   tz;
    logic [31:0]  secs;
    logic         typed;
    ecal_result_t golden;
  } dir_row_t;

  localparam int DirCount = 22;
  localparam dir_row_t DirRows [DirCount] = '{
    {TzZero,    32'd0,          1'b1, FirstSecond},
    {TzZero,    32'd4102444799, 1'b1, LastSecond},
    {TzZero,    32'd4102444800, 1'b1, Beyond},
    {TzZero,    32'hFFFFFFFF,   1'b1, Beyond},
    {TzZero,    32'd68169600,   1'b0, Predicted},
    {TzZero,    32'd951868799,  1'b0, Predicted},
    {TzZero,    32'd1234567890, 1'b0, Predicted},
    {TzMinus1,  32'd0,          1'b1, Beyond},
    {TzMinus1,  32'd3599,       1'b1, Beyond},
    {TzMinus1,  32'd3600,       1'b1, FirstSecond},
    {TzPlus14,  32'd4102394399, 1'b1, LastSecond},
    {TzPlus14,  32'd4102394400, 1'b1, Beyond},
    {TzPlus14,  32'd946634399,  1'b0, Predicted},
    {TzPlus14,  32'd946634400,  1'b0, Predicted},
    {TzMinus12, 32'd43199,      1'b1, Beyond},
    {TzMinus12, 32'd43200,      1'b1, FirstSecond},
    {TzMinus12, 32'hFFFFFFFF,   1'b1, Beyond},
    {TzMinus16, 32'd57599,      1'b1, Beyond},
    {TzMinus16, 32'd57600,      1'b1, FirstSecond},
    {TzPlus15,  32'd0,          1'b1, FirstAt15h},
    {TzPlus15,  32'd4102390799, 1'b1, LastSecond},
    {TzPlus15,  32'd4102390800, 1'b1, Beyond}
  };

  localparam int MonthFirst [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic        out_out_of_range;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  ecal_result_t pending_dates [$];
  logic [4:0]   tz_now = TzZero;
  bit           quiet = 1'b0;
  int           errors = 0;
  int           idle_cycles = 0;

  epoch_seconds_to_calendar_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_out_of_range (out_out_of_range),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic string date_text(input ecal_result_t r);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d oor %0d", r.year, r.month, r.day_of_month,
                     r.hour, r.minute, r.second, r.out_of_range);
  endfunction

  function automatic ecal_result_t calendar_of(input logic [31:0] secs, input logic [4:0] tz);
    longint t;
    longint days;
    longint tod;
    int year;
    int mon;
    int ylen;
    int mstart;
    bit leap;
    ecal_result_t r;
    r = '0;
    t = longint'(secs) + longint'($signed(tz)) * 3600;
    if (t < 0 || t >= RangeEnd) begin
      r.out_of_range = 1'b1;
      return r;
    end
    days = t / 86400;
    tod = t % 86400;
    year = 1970;
    ylen = 365;
    while (days >= ylen) begin
      days = days - ylen;
      year++;
      ylen = (year % 4 == 0) ? 366 : 365;
    end
    leap = (year % 4 == 0);
    mon = 11;
    mstart = MonthFirst[11] + (leap ? 1 : 0);
    while (mon > 0 && days < mstart) begin
      mon--;
      mstart = MonthFirst[mon] + ((leap && mon >= 2) ? 1 : 0);
    end
    days = days - mstart;
    r.year = 12'(year);
    r.month = 4'(mon + 1);
    r.day_of_month = 5'(days + 1);
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod % 3600) / 60);
    r.second = 6'(tod % 60);
    return r;
  endfunction

  function automatic logic [31:0] pick_secs(input logic [4:0] tz);
    longint off;
    longint base;
    off = longint'($signed(tz)) * 3600;
    case ($urandom_range(9, 0))
      0: return $urandom();
      1, 2: base = -off;
      3, 4: base = RangeEnd - off;
      5, 6: base = longint'($urandom_range(47481, 0)) * 86400 - off;
      default: return $urandom_range(32'd4102444799, 0);
    endcase
    return 32'(base + longint'($urandom_range(400, 0)) - 200);
  endfunction

  task automatic send_request(input logic [31:0] secs, input logic typed,
                              input ecal_result_t golden);
    int gap;
    ecal_result_t want;
    gap = quiet ? 0 : $urandom_range(11, 0);
    want = typed ? golden : calendar_of(secs, tz_now);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(want);
  endtask

  // The register is only written once the pipeline has drained.
  task automatic set_offset(input logic [4:0] tz);
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (ecal_pkg::Stages + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= tz;
    @(posedge clk);
    cfg_we <= 1'b0;
    tz_now = tz;
  endtask

  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(11, 0);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    ecal_result_t got;
    ecal_result_t want;
    got = {out_year, out_month, out_day_of_month, out_hour, out_minute, out_second,
           out_out_of_range};
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %s", $time, date_text(got));
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected %s, got %s", $time, date_text(want),
                   date_text(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout with %0d results outstanding", $time, pending_dates.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int phase;
    int k;
    logic [4:0] tz_pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DirCount; k++) begin
      if (DirRows[k].tz != tz_now) begin
        set_offset(DirRows[k].tz);
      end
      send_request(DirRows[k].secs, DirRows[k].typed, DirRows[k].golden);
    end

    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: tz_pick = TzMinus12;
        1: tz_pick = TzPlus14;
        2: tz_pick = TzMinus16;
        3: tz_pick = TzPlus15;
        4: tz_pick = TzZero;
        default: tz_pick = 5'($urandom_range(31, 0));
      endcase
      set_offset(tz_pick);
      quiet = (phase % 4 == 3);
      for (k = 0; k < PhaseItems; k++) begin
        send_request(pick_secs(tz_now), 1'b0, Predicted);
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (ecal_pkg::Stages + 4) @(posedge clk);
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ epoch_seconds_to_calendar_top.f @@
hw/rtl/ecal_pkg.sv
hw/rtl/ecal_conv.sv
hw/rtl/epoch_seconds_to_calendar_top.sv
tb/sv/tb_epoch_seconds_to_calendar_top.sv
